/* hdl/bars_pkg.sv */
package bars_pkg;

  // ring queue geometry: DEPTH slots, at most DEPTH-1 requests held
  localparam int unsigned Depth = 8;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 8;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_SERVE = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegServerPeriod = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegBudgetUnits  = CfgIdxW'(1);

  // queue control and status
  typedef struct packed {
    logic add;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic empty_next;
    logic dropped;
  } q_stat_t;

  // budget control and status
  typedef struct packed {
    logic tick;
    logic spend;
  } bud_ctrl_t;

  typedef struct packed {
    logic             avail;
    logic             recharge;
    logic [WordW-1:0] left_next;
  } bud_stat_t;

  // ring pointer step, wraps at the last slot
  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

endpackage

/* hdl/bars_if.sv */
// request channel
interface bars_req_if import bars_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [WordW-1:0] request_handler;
  logic [WordW-1:0] request_arg;
  logic [WordW-1:0] tick_now;

  modport source (output valid, kind, request_handler, request_arg, tick_now,
                  input ready);
  modport sink   (input valid, kind, request_handler, request_arg, tick_now,
                  output ready);
endinterface

// result channel
interface bars_res_if import bars_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             served;
  logic [WordW-1:0] out_handler;
  logic [WordW-1:0] out_arg;
  logic             dropped_oldest;
  logic             recharged;
  logic             queue_empty;
  logic             budget_exhausted;
  logic [WordW-1:0] budget_left;

  modport source (output valid, served, out_handler, out_arg, dropped_oldest,
                  recharged, queue_empty, budget_exhausted, budget_left,
                  input ready);
  modport sink   (input valid, served, out_handler, out_arg, dropped_oldest,
                  recharged, queue_empty, budget_exhausted, budget_left,
                  output ready);
endinterface

// configuration write channel
interface bars_cfg_if import bars_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/bars_ram.sv */
module bars_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bars_queue.sv */
module bars_queue import bars_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  input  logic [WordW-1:0] wr_handler_i,
  input  logic [WordW-1:0] wr_arg_i,
  output q_stat_t          stat_o,
  output logic [WordW-1:0] rd_handler_o,
  output logic [WordW-1:0] rd_arg_o
);

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] wr_step;
  logic            full;

  // pointer update: a full queue drops its oldest request on add
  always_comb begin
    wr_step  = ring_next(wr_ptr_q);
    full     = (wr_step == rd_ptr_q);
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    if (ctrl_i.add) begin
      wr_ptr_d = wr_step;
      if (full) begin
        rd_ptr_d = ring_next(rd_ptr_q);
      end
    end else if (ctrl_i.pop) begin
      rd_ptr_d = ring_next(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  assign stat_o.empty      = (rd_ptr_q == wr_ptr_q);
  assign stat_o.empty_next = (rd_ptr_d == wr_ptr_d);
  assign stat_o.dropped    = ctrl_i.add & full;

  // request storage, read data lands alongside the result register
  bars_ram #(.Width(WordW), .Depth(Depth)) u_handler_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.add),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_handler_i),
    .re_i    (ctrl_i.pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_handler_o)
  );

  bars_ram #(.Width(WordW), .Depth(Depth)) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.add),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_arg_i),
    .re_i    (ctrl_i.pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_arg_o)
  );

endmodule

/* hdl/bars_budget.sv */
module bars_budget import bars_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  bars_cfg_if.sink         cfg_i,
  input  bud_ctrl_t        ctrl_i,
  input  logic [WordW-1:0] tick_now_i,
  output bud_stat_t        stat_o
);

  logic [WordW-1:0] period_q;
  logic [WordW-1:0] units_q;
  logic [WordW-1:0] left_q, left_d;
  logic [WordW:0]   boundary_q, boundary_d;
  logic             reached;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= WordW'(1);
      units_q  <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegServerPeriod) begin
        period_q <= cfg_i.data;
      end else if (cfg_i.index == RegBudgetUnits) begin
        units_q <= cfg_i.data;
      end
    end
  end

  // refill at the running boundary, spend one unit per served request
  always_comb begin
    reached    = ({1'b0, tick_now_i} >= boundary_q);
    left_d     = left_q;
    boundary_d = boundary_q;
    if (ctrl_i.tick && reached) begin
      left_d     = units_q;
      boundary_d = boundary_q + {1'b0, period_q};
    end else if (ctrl_i.spend) begin
      left_d = left_q - WordW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      boundary_q <= '0;
    end else begin
      left_q     <= left_d;
      boundary_q <= boundary_d;
    end
  end

  assign stat_o.avail     = (left_q != '0);
  assign stat_o.recharge  = ctrl_i.tick & reached;
  assign stat_o.left_next = left_d;

endmodule

/* hdl/budgeted_aperiodic_request_server.sv */
// channel | role   | moves
// req_i   | sink   | add, tick or serve request with its payload
// res_o   | source | one result per request: served words and status
// cfg_i   | sink   | register write (index, data), always ready
//
// one request per cycle unless stalled as below; its result is registered and shows the next cycle.
// queue words come from a ram with registered read, read beside the result.
// req_i.ready is low only while a result waits and res_o.ready is low.
// reset clears pointers, budget and boundary; queue words stay unwritten.
module budgeted_aperiodic_request_server import bars_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bars_req_if.sink   req_i,
  bars_res_if.source res_o,
  bars_cfg_if.sink   cfg_i
);

  logic      accept;
  kind_e     kind;
  logic      serve_go;
  q_ctrl_t   q_ctrl;
  q_stat_t   q_stat;
  bud_ctrl_t bud_ctrl;
  bud_stat_t bud_stat;

  logic [WordW-1:0] rd_handler;
  logic [WordW-1:0] rd_arg;

  logic             valid_q;
  logic             served_q;
  logic             dropped_q;
  logic             recharged_q;
  logic             empty_q;
  logic             exhausted_q;
  logic [WordW-1:0] left_q;

  // handshake: a new request enters whenever the result slot frees up
  assign req_i.ready = !valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = kind_e'(req_i.kind);

  // decode
  assign serve_go       = accept && (kind == KIND_SERVE) && bud_stat.avail && !q_stat.empty;
  assign q_ctrl.add     = accept && (kind == KIND_ADD);
  assign q_ctrl.pop     = serve_go;
  assign bud_ctrl.tick  = accept && (kind == KIND_TICK);
  assign bud_ctrl.spend = serve_go;

  bars_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (q_ctrl),
    .wr_handler_i (req_i.request_handler),
    .wr_arg_i     (req_i.request_arg),
    .stat_o       (q_stat),
    .rd_handler_o (rd_handler),
    .rd_arg_o     (rd_arg)
  );

  bars_budget u_budget (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .ctrl_i     (bud_ctrl),
    .tick_now_i (req_i.tick_now),
    .stat_o     (bud_stat)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      served_q    <= serve_go;
      dropped_q   <= q_stat.dropped;
      recharged_q <= bud_stat.recharge;
      empty_q     <= q_stat.empty_next;
      exhausted_q <= (bud_stat.left_next == '0);
      left_q      <= bud_stat.left_next;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.served           = served_q;
  assign res_o.out_handler      = served_q ? rd_handler : '0;
  assign res_o.out_arg          = served_q ? rd_arg : '0;
  assign res_o.dropped_oldest   = dropped_q;
  assign res_o.recharged        = recharged_q;
  assign res_o.queue_empty      = empty_q;
  assign res_o.budget_exhausted = exhausted_q;
  assign res_o.budget_left      = left_q;

endmodule

/* tb/sv/budgeted_aperiodic_request_server_tb.sv */
`timescale 1ns / 100ps

module budgeted_aperiodic_request_server_tb import bars_pkg::*; ();

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned PhaseItems = 205;
  // an index past the register map, must be ignored
  localparam logic [CfgIdxW-1:0] RegUnmapped = CfgIdxW'(2);

  // idling modes, one per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] handler;
    logic [WordW-1:0] arg;
    logic [WordW-1:0] tick;
  } request_t;

  typedef struct packed {
    logic             served;
    logic [WordW-1:0] out_handler;
    logic [WordW-1:0] out_arg;
    logic             dropped_oldest;
    logic             recharged;
    logic             queue_empty;
    logic             budget_exhausted;
    logic [WordW-1:0] budget_left;
  } outcome_t;

  // server state mirror and expected outcome store
  class server_scoreboard;
    logic [WordW-1:0] handler_ram [Depth];
    logic [WordW-1:0] arg_ram [Depth];
    logic [PtrW-1:0]  head;
    logic [PtrW-1:0]  tail;
    logic [WordW-1:0] budget_left;
    logic [WordW:0]   boundary;
    logic [WordW-1:0] period;
    logic [WordW-1:0] units;
    outcome_t         expected_outcomes [$];
    int unsigned      mismatches;

    function new();
      head        = '0;
      tail        = '0;
      budget_left = '0;
      boundary    = '0;
      period      = WordW'(1);
      units       = '0;
      mismatches  = 0;
    endfunction

    function logic [PtrW-1:0] slot_after(input logic [PtrW-1:0] p);
      return PtrW'((p + 1) % Depth);
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
      if (idx == RegServerPeriod) begin
        period = data;
      end else if (idx == RegBudgetUnits) begin
        units = data;
      end
    endfunction

    // apply one accepted request and queue the outcome it must give
    function void note_request(input request_t r);
      outcome_t o;
      o = '0;
      case (r.kind)
        KIND_ADD: begin
          if (slot_after(tail) == head) begin
            head = slot_after(head);
            o.dropped_oldest = 1'b1;
          end
          handler_ram[tail] = r.handler;
          arg_ram[tail]     = r.arg;
          tail = slot_after(tail);
        end
        KIND_TICK: begin
          if ({1'b0, r.tick} >= boundary) begin
            budget_left = units;
            boundary    = boundary + {1'b0, period};
            o.recharged = 1'b1;
          end
        end
        KIND_SERVE: begin
          if (budget_left != '0 && head != tail) begin
            o.served      = 1'b1;
            o.out_handler = handler_ram[head];
            o.out_arg     = arg_ram[head];
            head          = slot_after(head);
            budget_left   = budget_left - WordW'(1);
          end
        end
        default: ;
      endcase
      o.queue_empty      = (head == tail);
      o.budget_exhausted = (budget_left == '0);
      o.budget_left      = budget_left;
      expected_outcomes.push_back(o);
    endfunction

    function void fail_note(input string what, input outcome_t exp_o, input outcome_t got);
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("%0t %s", $realtime, what);
        $display("  expected srv=%0b h=%h a=%h drop=%0b rch=%0b emp=%0b exh=%0b left=%h",
                 exp_o.served, exp_o.out_handler, exp_o.out_arg, exp_o.dropped_oldest,
                 exp_o.recharged, exp_o.queue_empty, exp_o.budget_exhausted,
                 exp_o.budget_left);
        $display("  actual   srv=%0b h=%h a=%h drop=%0b rch=%0b emp=%0b exh=%0b left=%h",
                 got.served, got.out_handler, got.out_arg, got.dropped_oldest,
                 got.recharged, got.queue_empty, got.budget_exhausted, got.budget_left);
      end
    endfunction

    function void check_result(input outcome_t got);
      outcome_t exp_o;
      if (expected_outcomes.size() == 0) begin
        fail_note("result with no request outstanding", '0, got);
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (got.served !== exp_o.served || got.out_handler !== exp_o.out_handler ||
            got.out_arg !== exp_o.out_arg || got.dropped_oldest !== exp_o.dropped_oldest ||
            got.recharged !== exp_o.recharged || got.queue_empty !== exp_o.queue_empty ||
            got.budget_exhausted !== exp_o.budget_exhausted ||
            got.budget_left !== exp_o.budget_left) begin
          fail_note("result mismatch", exp_o, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bars_req_if req_if ();
  bars_res_if res_if ();
  bars_cfg_if cfg_if ();

  budgeted_aperiodic_request_server u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  server_scoreboard sb = new();
  int unsigned      sender_gap_pct;
  int unsigned      stall_pct;
  int unsigned      cycle_count;
  logic [WordW-1:0] tick_clock;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    res_if.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // observe accepted requests, register writes and results
  always @(posedge clk_i) begin
    request_t r;
    outcome_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.index, cfg_if.data);
      end
      if (req_if.valid && req_if.ready) begin
        r.kind    = kind_e'(req_if.kind);
        r.handler = req_if.request_handler;
        r.arg     = req_if.request_arg;
        r.tick    = req_if.tick_now;
        sb.note_request(r);
      end
      if (res_if.valid && res_if.ready) begin
        got.served           = res_if.served;
        got.out_handler      = res_if.out_handler;
        got.out_arg          = res_if.out_arg;
        got.dropped_oldest   = res_if.dropped_oldest;
        got.recharged        = res_if.recharged;
        got.queue_empty      = res_if.queue_empty;
        got.budget_exhausted = res_if.budget_exhausted;
        got.budget_left      = res_if.budget_left;
        sb.check_result(got);
      end
    end
  end

  // present one request, with random gaps in front, until accepted
  task automatic send_request(input request_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           = 1'b1;
    req_if.kind            = r.kind;
    req_if.request_handler = r.handler;
    req_if.request_arg     = r.arg;
    req_if.tick_now        = r.tick;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_kind(input kind_e k, input logic [WordW-1:0] h,
                           input logic [WordW-1:0] a, input logic [WordW-1:0] t);
    request_t r;
    r.kind    = k;
    r.handler = h;
    r.arg     = a;
    r.tick    = t;
    send_request(r);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // tick value: near the running boundary, a steady clock, or anywhere
  function automatic logic [WordW-1:0] pick_tick();
    logic [WordW-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (sb.boundary[WordW]) begin
          t = $urandom;
        end else begin
          t = sb.boundary[WordW-1:0];
          case ($urandom_range(0, 2))
            0: t = t - WordW'(1);
            2: t = t + WordW'($urandom_range(1, 3));
            default: ;
          endcase
        end
      end
      4, 5, 6, 7: begin
        tick_clock = tick_clock + WordW'($urandom_range(0, 3));
        t = tick_clock;
      end
      8: t = $urandom;
      default: t = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return t;
  endfunction

  // random request, leaning towards adds or serves in bursts
  function automatic request_t random_request(input bit add_lean);
    request_t    r;
    int unsigned roll;
    roll      = $urandom_range(0, 99);
    r.handler = $urandom;
    r.arg     = $urandom;
    r.tick    = pick_tick();
    if (roll < 4) begin
      r.kind = KIND_IDLE;
    end else if (roll < 28) begin
      r.kind = KIND_TICK;
    end else if (roll < (add_lean ? 72 : 45)) begin
      r.kind = KIND_ADD;
    end else begin
      r.kind = KIND_SERVE;
    end
    return r;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin sender_gap_pct = 48; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_gap_pct = 0;  stall_pct = 48; end
      IDLE_BOTH:     begin sender_gap_pct = 29; stall_pct = 29; end
      default:       begin sender_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic run_phase(input logic [WordW-1:0] period, input logic [WordW-1:0] units,
                           input idle_mode_e mode);
    bit add_lean;
    drain();
    write_reg(RegServerPeriod, period);
    write_reg(RegBudgetUnits, units);
    set_idling(mode);
    add_lean = 1'b0;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i % 16 == 0) add_lean = $urandom_range(0, 1);
      // hold off mid-phase until the server has caught up
      if (i == PhaseItems / 2) drain();
      send_request(random_request(add_lean));
    end
  endtask

  initial begin
    req_if.valid           = 1'b0;
    req_if.kind            = KIND_IDLE;
    req_if.request_handler = '0;
    req_if.request_arg     = '0;
    req_if.tick_now        = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    res_if.ready           = 1'b0;
    sender_gap_pct         = 0;
    stall_pct              = 0;
    cycle_count            = 0;
    tick_clock             = '0;
    rst_ni                 = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: no budget, so nothing can be served
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_IDLE, '1, '1, '1);
    drain();

    // directed: refill, serve to exhaustion, overfill, far-late ticks
    write_reg(RegServerPeriod, WordW'(3));
    write_reg(RegBudgetUnits, WordW'(2));
    write_reg(RegUnmapped, '1);
    send_kind(KIND_TICK, '0, '0, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_ADD, '0, '0, '0);
    send_kind(KIND_ADD, '1, '1, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    for (int i = 0; i < Depth + 1; i++) begin
      send_kind(KIND_ADD, $urandom, $urandom, $urandom);
    end
    send_kind(KIND_TICK, '0, '0, WordW'(2));
    send_kind(KIND_TICK, '0, '0, '1);
    send_kind(KIND_TICK, '0, '0, '1);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_SERVE, '0, '0, '0);
    send_kind(KIND_IDLE, '0, '0, '0);

    // random phases; the largest period goes last since it ends all refills
    run_phase(WordW'(1), WordW'(3), IDLE_NONE);
    run_phase('0, WordW'(2), IDLE_SENDER);
    run_phase(WordW'(5), '0, IDLE_RECEIVER);
    run_phase(WordW'(16), WordW'(1), IDLE_BOTH);
    run_phase(WordW'(2), WordW'(4), IDLE_NONE);
    run_phase(WordW'(1000), $urandom, IDLE_SENDER);
    run_phase($urandom, WordW'($urandom_range(1, 6)), IDLE_RECEIVER);
    run_phase('1, '1, IDLE_BOTH);
    drain();

    if (sb.pending() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
